// ----- src/assert_macros.svh -----
// Assertion macros shared by the pixel decoder RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/prd_pkg.sv -----
// Package for the PBM row pixel decoder: command and status types, character
// codes, result status codes and register indexes. No dependencies.
package prd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COL_W   = 12;
    localparam int WIDTH_W = 13;
    localparam int STAT_W  = 2;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = 3;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_ONE    = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_WS_LO  = 8'd9;
    localparam logic [BYTE_W-1:0] CHAR_WS_HI  = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'd32;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_PIXEL    = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADCHAR  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EARLYEND = 2'd2;

    // Register indexes (taken from paddr[2])
    localparam logic REG_PLAIN_MODE = 1'b0;
    localparam logic REG_ROW_WIDTH  = 1'b1;

    // Widest row the counter supports
    localparam int WIDTH_LIMIT = 4096;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_BADCHAR,
        CMD_EOS,
        CMD_RAW
    } cmd_kind_t;

    // One classified transaction; for CMD_PIXEL the pixel sits in data[0]
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- src/prd_front.sv -----
// Front end of the pixel decoder: accepts input transactions and classifies
// them into commands for the queue. Depends on prd_pkg.
module prd_front (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic [0:0]                 s_tuser,   // [0] stream_end
    input  logic                       plain_mode,
    input  prd_pkg::q_status_t         q_status,
    output logic                       push,
    output prd_pkg::cmd_t              push_cmd
);
    import prd_pkg::*;

    logic accept;
    logic is_space;
    logic skip;

    // Accept whenever the queue has room
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    assign is_space = ((s_tdata >= CHAR_WS_LO) && (s_tdata <= CHAR_WS_HI))
                      || (s_tdata == CHAR_SPACE);

    // Classify the transaction; drop whitespace in plain mode
    always_comb begin
        skip          = 1'b0;
        push_cmd.kind = CMD_RAW;
        push_cmd.data = s_tdata;
        priority if (s_tuser[0]) begin
            push_cmd.kind = CMD_EOS;
        end else if (!plain_mode) begin
            push_cmd.kind = CMD_RAW;
        end else if (is_space) begin
            skip = 1'b1;
        end else if ((s_tdata == CHAR_ZERO) || (s_tdata == CHAR_ONE)) begin
            push_cmd.kind = CMD_PIXEL;
            push_cmd.data = {{(BYTE_W-1){1'b0}}, (s_tdata == CHAR_ZERO)};
        end else begin
            push_cmd.kind = CMD_BADCHAR;
        end
    end

    assign push = accept && !skip;

endmodule

// ----- src/prd_queue.sv -----
// Short command queue between the front and back end of the pixel decoder.
// Depends on prd_pkg.
module prd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  prd_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output prd_pkg::cmd_t       head_cmd,
    output prd_pkg::q_status_t  q_status
);
    import prd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_FULL);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store commands; no reset on payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/prd_back.sv -----
// Back end of the pixel decoder: executes queued commands, keeps the column
// counter and drives the result channel through an output register.
// Depends on prd_pkg.
module prd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  prd_pkg::cmd_t                head_cmd,
    input  prd_pkg::q_status_t           q_status,
    output logic                         pop,
    input  logic [prd_pkg::WIDTH_W-1:0]  eff_width,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,  // [0] pixel_value, [12:1] column_index,
                                                   // [13] row_complete, [15:14] zero
    output logic [1:0]                   m_tuser,  // [1:0] status
    output logic                         m_tlast   // last_of_item
);
    import prd_pkg::*;

    localparam logic [BIT_IDX_W-1:0] BIT_TOP = BIT_IDX_W'(BITS_PER_BYTE - 1);

    logic [COL_W-1:0]     col_reg, col_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg, bit_idx_next;
    logic                 valid_reg;
    logic                 pix_reg, rc_reg, last_reg;
    logic [COL_W-1:0]     rcol_reg;
    logic [STAT_W-1:0]    stat_reg;

    logic                 slot_free, emit;
    logic [WIDTH_W-1:0]   col_inc;
    logic                 row_done;
    logic                 r_pix, r_rc, r_last;
    logic [STAT_W-1:0]    r_stat;

    assign slot_free = !valid_reg || m_tready;
    assign col_inc   = {1'b0, col_reg} + WIDTH_W'(1);
    assign row_done  = (col_inc >= eff_width);

    // Execute the head command, at most one result per cycle while the output register is free
    always_comb begin
        pop          = 1'b0;
        emit         = 1'b0;
        r_pix        = 1'b0;
        r_rc         = 1'b0;
        r_last       = 1'b1;
        r_stat       = ST_PIXEL;
        col_next     = col_reg;
        bit_idx_next = bit_idx_reg;
        if (!q_status.empty && slot_free) begin
            unique case (head_cmd.kind)
                CMD_EOS: begin
                    pop      = 1'b1;
                    emit     = (col_reg != '0);
                    r_stat   = ST_EARLYEND;
                    col_next = '0;
                end
                CMD_BADCHAR: begin
                    pop      = 1'b1;
                    emit     = 1'b1;
                    r_stat   = ST_BADCHAR;
                    col_next = '0;
                end
                CMD_PIXEL: begin
                    pop      = 1'b1;
                    emit     = 1'b1;
                    r_pix    = head_cmd.data[0];
                    r_rc     = row_done;
                    col_next = row_done ? '0 : col_inc[COL_W-1:0];
                end
                CMD_RAW: begin
                    emit     = 1'b1;
                    r_pix    = !head_cmd.data[bit_idx_reg];
                    r_rc     = row_done;
                    r_last   = row_done || (bit_idx_reg == '0);
                    col_next = row_done ? '0 : col_inc[COL_W-1:0];
                    // Drop the padding bits once the row is complete
                    if (r_last) begin
                        pop          = 1'b1;
                        bit_idx_next = BIT_TOP;
                    end else begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                    end
                end
                default: begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            bit_idx_reg <= BIT_TOP;
            valid_reg   <= 1'b0;
        end else begin
            col_reg     <= col_next;
            bit_idx_reg <= bit_idx_next;
            if (slot_free) begin
                valid_reg <= emit;
            end
        end
    end

    // Load the output register; no reset on payload
    always_ff @(posedge aclk) begin
        if (slot_free && emit) begin
            pix_reg  <= r_pix;
            rcol_reg <= col_reg;
            rc_reg   <= r_rc;
            stat_reg <= r_stat;
            last_reg <= r_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, rc_reg, rcol_reg, pix_reg};
    assign m_tuser  = stat_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- src/pbm_row_pixel_decoder_top.sv -----
// PBM row pixel decoder, top level: configuration registers, front end,
// command queue and back end. Depends on prd_pkg, prd_front, prd_queue,
// prd_back and assert_macros.svh.
//
// Decodes a PBM bitmap byte stream into inverted pixels with their column
// position. Plain mode takes one byte per cycle while the queue has room;
// whitespace gives no result, '0'/'1' one pixel, any other byte an
// invalid-character result. Raw mode gives one pixel per cycle from the MSB
// down, up to 8 pixels per byte (fewer when the row ends inside it); a
// stream end gives at most one result. The back end emits at most one
// result per cycle, while its single output register is free. A two-entry
// command queue lets the input side keep accepting while the back end works
// or the result channel stalls. Write plain_mode at 0x0 and row_width at 0x4
// only while idle; the row width is clamped to 1..min(MAX_ROW_WIDTH, 4096).
module pbm_row_pixel_decoder_top #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] stream_end
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] pixel_value, [12:1] column_index,
                                   // [13] row_complete, [15:14] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,   // last_of_item
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import prd_pkg::*;

    `include "assert_macros.svh"

    localparam int CAP_INT = (MAX_ROW_WIDTH < WIDTH_LIMIT) ? MAX_ROW_WIDTH : WIDTH_LIMIT;
    localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(CAP_INT);

    logic                plain_mode_reg;
    logic [WIDTH_W-1:0]  row_width_reg;
    logic [WIDTH_W-1:0]  eff_width_reg, eff_width_next;
    logic                cfg_write;

    logic                push, pop;
    cmd_t                push_cmd, head_cmd;
    q_status_t           q_status;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        eff_width_next = pwdata[WIDTH_W-1:0];
        if (pwdata[WIDTH_W-1:0] == '0) begin
            eff_width_next = WIDTH_W'(1);
        end else if (pwdata[WIDTH_W-1:0] > WIDTH_CAP) begin
            eff_width_next = WIDTH_CAP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plain_mode_reg <= 1'b0;
            row_width_reg  <= WIDTH_W'(1);
            eff_width_reg  <= WIDTH_W'(1);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_PLAIN_MODE: plain_mode_reg <= pwdata[0];
                REG_ROW_WIDTH: begin
                    row_width_reg <= pwdata[WIDTH_W-1:0];
                    eff_width_reg <= eff_width_next;
                end
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (paddr[2])
            REG_PLAIN_MODE: prdata = {31'b0, plain_mode_reg};
            REG_ROW_WIDTH:  prdata = {{(32-WIDTH_W){1'b0}}, row_width_reg};
            default:        prdata = '0;
        endcase
    end

    prd_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .plain_mode (plain_mode_reg),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    prd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    prd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_cmd  (head_cmd),
        .q_status  (q_status),
        .pop       (pop),
        .eff_width (eff_width_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Error results carry no pixel, never complete a row and end their transaction
    `ASSERT_IMPLIES(a_err_result, m_tvalid && (m_tuser != ST_PIXEL), (m_tdata[0] == 1'b0) && (m_tdata[13] == 1'b0) && m_tlast, "error result malformed")
    // A completed row always ends the transaction's results
    `ASSERT_IMPLIES(a_row_ends_item, m_tvalid && m_tdata[13], m_tlast, "row end without last")
    // The queue never reads empty and full at once, and stalls input only when full
    `ASSERT_ALWAYS(a_queue_state, !(q_status.empty && q_status.full) && (s_tready == !q_status.full), "queue status inconsistent")

endmodule

// ----- bench/prd_result_checker.sv -----
// Result checker for the PBM row pixel decoder: tracks register writes, predicts
// the pixel and error results of each input transaction and compares them in order.
// Depends on prd_pkg.
module prd_result_checker #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] stream_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [0] pixel_value, [12:1] column_index,
                                   // [13] row_complete, [15:14] zero
    input  logic [1:0]  m_tuser,   // [1:0] status
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          due_count,
    output int          checked_count,
    output int          fail_count
);
    import prd_pkg::*;

    typedef struct packed {
        logic              pixel;
        logic [COL_W-1:0]  column;
        logic              row_done;
        logic [STAT_W-1:0] status;
        logic              last;
    } decoded_pixel_t;

    logic               plain_sel;
    logic [WIDTH_W-1:0] row_width_reg;
    logic [COL_W-1:0]   column_pos;
    decoded_pixel_t     pixels_due[$];
    int                 n_checked;
    int                 n_failed;

    // Clamp the programmed width to the supported range
    function automatic int clamped_width();
        int cap;
        int w;
        cap = (MAX_ROW_WIDTH < WIDTH_LIMIT) ? MAX_ROW_WIDTH : WIDTH_LIMIT;
        w = int'(row_width_reg);
        if (w < 1) w = 1;
        if (w > cap) w = cap;
        return w;
    endfunction

    // Queue one pixel at the current column and advance or wrap the column
    task automatic push_pixel(input logic value, input int width, input logic final_bit,
                              output logic closed);
        decoded_pixel_t r;
        closed = (int'(column_pos) + 1 >= width);
        r.pixel    = value;
        r.column   = column_pos;
        r.row_done = closed;
        r.status   = ST_PIXEL;
        r.last     = closed | final_bit;
        pixels_due.push_back(r);
        column_pos = closed ? '0 : column_pos + 1'b1;
    endtask

    // Queue an error result at the current column and restart the row
    task automatic push_error(input logic [STAT_W-1:0] code);
        decoded_pixel_t r;
        r.pixel    = 1'b0;
        r.column   = column_pos;
        r.row_done = 1'b0;
        r.status   = code;
        r.last     = 1'b1;
        pixels_due.push_back(r);
        column_pos = '0;
    endtask

    // Work out every result one input transaction causes
    task automatic predict_item(input logic [BYTE_W-1:0] b, input logic eos);
        int   width;
        int   bit_idx;
        logic closed;
        logic is_space;
        width = clamped_width();
        if (eos) begin
            // stream end between rows is silent
            if (column_pos != '0) push_error(ST_EARLYEND);
        end else if (plain_sel) begin
            is_space = (b >= CHAR_WS_LO && b <= CHAR_WS_HI) || b == CHAR_SPACE;
            if (b == CHAR_ZERO || b == CHAR_ONE) begin
                push_pixel(b == CHAR_ZERO, width, 1'b1, closed);
            end else if (!is_space) begin
                push_error(ST_BADCHAR);
            end
        end else begin
            // MSB first, stop at row end and drop the padding bits
            closed = 1'b0;
            bit_idx = BITS_PER_BYTE - 1;
            while (!closed && bit_idx >= 0) begin
                push_pixel(~b[bit_idx], width, bit_idx == 0, closed);
                bit_idx--;
            end
        end
    endtask

    always @(posedge aclk) begin
        decoded_pixel_t want;
        if (!aresetn) begin
            plain_sel     = 1'b0;
            row_width_reg = 13'd1;
            column_pos    = '0;
            pixels_due.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_PLAIN_MODE) plain_sel = pwdata[0];
                else row_width_reg = pwdata[WIDTH_W-1:0];
            end
            if (s_tvalid && s_tready) predict_item(s_tdata, s_tuser[0]);
            // Compare each accepted result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (pixels_due.size() == 0) begin
                    n_failed++;
                    $display("%0t: unexpected result: tdata=%h tuser=%0d tlast=%0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = pixels_due.pop_front();
                    n_checked++;
                    if (m_tdata[0] !== want.pixel || m_tdata[12:1] !== want.column ||
                        m_tdata[13] !== want.row_done || m_tdata[15:14] !== 2'b00 ||
                        m_tuser !== want.status || m_tlast !== want.last) begin
                        n_failed++;
                        $display("%0t: mismatch: expected pix=%0b col=%0d done=%0b st=%0d last=%0b",
                                 $time, want.pixel, want.column, want.row_done,
                                 want.status, want.last);
                        $display("%0t:           actual pix=%0b col=%0d done=%0b st=%0d last=%0b pad=%b",
                                 $time, m_tdata[0], m_tdata[12:1], m_tdata[13],
                                 m_tuser, m_tlast, m_tdata[15:14]);
                    end
                end
            end
        end
        due_count     <= pixels_due.size();
        checked_count <= n_checked;
        fail_count    <= n_failed;
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the PBM row pixel decoder: clock, reset, register writes,
// directed and random byte streams under several pacing phases, and the verdict.
// Depends on prd_pkg, pbm_row_pixel_decoder_top and prd_result_checker.
module tb;
    import prd_pkg::*;

    localparam int PHASES             = 4;
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int ITEMS_PER_SETTING  = 22;
    localparam int DRAIN_CYCLES       = 32;
    localparam int RUN_LIMIT          = 1_000_000;
    localparam logic [2:0] ADDR_PLAIN_MODE = {REG_PLAIN_MODE, 2'b00};
    localparam logic [2:0] ADDR_ROW_WIDTH  = {REG_ROW_WIDTH, 2'b00};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int due_count;
    int checked_count;
    int fail_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int settings_used  = 0;
    int send_idle_of[PHASES]  = '{0, 85, 0, 17};
    int recv_stall_of[PHASES] = '{0, 0, 85, 17};

    always #1 aclk = ~aclk;

    pbm_row_pixel_decoder_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    prd_result_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .due_count(due_count), .checked_count(checked_count), .fail_count(fail_count)
    );

    // Stall the result channel at the current phase's rate
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Setup then access cycle, then return the bus to idle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold one input transaction until it is taken, after a random gap
    task automatic send_item(input logic [7:0] data, input logic eos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= data;
        s_tuser[0] <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let silent items drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode_width(input logic plain, input logic [12:0] width);
        settle();
        reg_write(ADDR_PLAIN_MODE, {31'd0, plain});
        reg_write(ADDR_ROW_WIDTH, {19'd0, width});
        settings_used++;
    endtask

    initial begin
        int           counted;
        int           roll;
        logic         plain;
        logic [12:0]  width;
        logic [7:0]   data;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: raw bits, one-pixel rows; stream end at row start is silent
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        // Zero width acts as one
        set_mode_width(1'b0, 13'd0);
        send_item(8'h80, 1'b0);
        // Oversized width saturates; stream end mid-row
        set_mode_width(1'b0, 13'd8191);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'hFF, 1'b1);
        // Row ends inside a byte, rest is padding
        set_mode_width(1'b0, 13'd10);
        send_item(8'hAA, 1'b0);
        send_item(8'h55, 1'b0);
        // Plain text: digits, whitespace, bad characters mid-row and at row start
        set_mode_width(1'b1, 13'd4);
        send_item(CHAR_ZERO, 1'b0);
        send_item(CHAR_ONE, 1'b0);
        send_item(CHAR_WS_LO, 1'b0);
        send_item(CHAR_WS_HI, 1'b0);
        send_item(CHAR_SPACE, 1'b0);
        send_item(CHAR_ZERO, 1'b0);
        send_item(8'h08, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h0E, 1'b0);
        send_item(CHAR_ONE, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b1);
        // Mode change mid-row keeps the column
        set_mode_width(1'b0, 13'd12);
        send_item(8'hF0, 1'b0);
        set_mode_width(1'b1, 13'd12);
        send_item(CHAR_ONE, 1'b0);
        send_item(CHAR_ZERO, 1'b0);
        send_item(CHAR_ONE, 1'b0);
        send_item(CHAR_ONE, 1'b0);
        // Width lowered below the current column closes the row on the next pixel
        set_mode_width(1'b0, 13'd20);
        send_item(8'h00, 1'b0);
        set_mode_width(1'b0, 13'd5);
        send_item(8'hFF, 1'b0);

        // Random streams under each pacing phase
        for (int ph = 0; ph < PHASES; ph++) begin
            for (int st = 0; st < SETTINGS_PER_PHASE; st++) begin
                plain = 1'($urandom_range(0, 1));
                case (st)
                    0: width = ($urandom_range(0, 3) == 0) ? 13'd0 : 13'd1;
                    1: begin
                        case ($urandom_range(0, 2))
                            0: width = 13'd4096;
                            1: width = 13'd8191;
                            default: width = 13'd4095;
                        endcase
                    end
                    default: width = 13'($urandom_range(2, 40));
                endcase
                set_mode_width(plain, width);
                send_idle_pct  = send_idle_of[ph];
                recv_stall_pct = recv_stall_of[ph];
                counted = 0;
                while (counted < ITEMS_PER_SETTING) begin
                    roll = $urandom_range(0, 99);
                    data = 8'($urandom_range(0, 255));
                    if (roll >= 95) begin
                        send_item(data, 1'b1);
                    end else if (!plain) begin
                        send_item(data, 1'b0);
                        counted++;
                    end else if (roll < 70) begin
                        send_item(CHAR_ZERO + 8'($urandom_range(0, 1)), 1'b0);
                        counted++;
                    end else if (roll < 85) begin
                        roll = $urandom_range(0, 5);
                        send_item((roll == 5) ? CHAR_SPACE : CHAR_WS_LO + 8'(roll), 1'b0);
                    end else begin
                        send_item(data, 1'b0);
                        counted++;
                    end
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();

        $display("Sent %0d byte transactions over %0d register settings in four pacing phases.",
                 items_sent, settings_used);
        $display("Checked %0d result transactions, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0) begin
            $display("[pbm_row_pixel_decoder_top] OK");
        end else begin
            $display("[pbm_row_pixel_decoder_top] ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(RUN_LIMIT);
        $display("Timed out with %0d results outstanding.", due_count);
        $display("[pbm_row_pixel_decoder_top] ERROR");
        $finish;
    end

endmodule
